// File: sv/ple_pkg.sv
// Shared constants, codes and control types for the positional list engine.
// No dependencies; every other file in this folder but ple_ram imports this package.
package ple_pkg;

   // list sizing
   localparam int CAPACITY    = 256;
   localparam int HANDLE_BITS = 10;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // request / response field widths
   localparam int ACTION_W = 3;
   localparam int POS_W    = 9;
   localparam int STATUS_W = 2;

   // common width for position / count compares
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // action codes carried on the request word
   localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REM_FRONT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REM_BACK  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REM_AT    = 3'd5;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic out_free;
   } ctrl_sts_type;

endpackage

// File: sv/ple_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; the list datapath holds the slot store in one of these.
module ple_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/ple_ctrl.sv
// Controller state machine for the positional list engine.
// Depends on ple_pkg; drives the datapath through ctrl_cmd_type commands.
module ple_ctrl
   import ple_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_SHIFT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // take a word only while idle
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.step = 1'b1;
            // finish once the moves have drained and the result slot is free
            if (sts.done && sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_commit_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.done && sts.out_free)
      else $error("commit issued while busy or result slot occupied");
   a_start_leads_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_ready)
      else $error("accepted word did not leave idle");
   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("commit did not return to idle");
`endif

endmodule

// File: sv/ple_dpath.sv
// Datapath for the positional list engine: slot RAM, count, move sequencer
// and the result register. Depends on ple_pkg and ple_ram.
module ple_dpath
   import ple_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output ctrl_sts_type           sts,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [POS_W-1:0]       req_position,
   input  logic [HANDLE_BITS-1:0] req_item_handle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_removed_handle,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   // control state
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             wr_pend_ff, wr_pend_in;
   logic             cap_pend_ff, cap_pend_in;
   logic             first_ff, first_in;

   // operation payload
   logic                   is_ins_ff, is_ins_in;
   logic                   is_rem_ff, is_rem_in;
   status_type             status_ff, status_in;
   logic [ADDR_W-1:0]      at_ff, at_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [ADDR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0]      wr_addr_ff, wr_addr_in;
   logic [HANDLE_BITS-1:0] taken_ff, taken_in;

   // result register payload
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [HANDLE_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]      mem_raddr;
   logic [HANDLE_BITS-1:0] mem_rdata;

   // request decode
   logic [CMP_W-1:0] n_x, pos_x, at_x;
   logic             dec_ins, dec_rem;
   status_type       dec_status;
   logic             ok_ins, ok_rem;

   ple_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // decode action against the current count
   always_comb begin
      n_x        = CMP_W'(count_ff);
      pos_x      = CMP_W'(req_position);
      at_x       = '0;
      dec_ins    = 1'b0;
      dec_rem    = 1'b0;
      dec_status = ST_OK;
      case (req_action)
         ACT_INS_FRONT: begin
            dec_ins = 1'b1;
         end
         ACT_INS_BACK: begin
            dec_ins = 1'b1;
            at_x    = n_x;
         end
         ACT_INS_AT: begin
            dec_ins = 1'b1;
            at_x    = pos_x;
         end
         ACT_REM_FRONT: begin
            dec_rem = 1'b1;
         end
         ACT_REM_BACK: begin
            dec_rem = 1'b1;
            at_x    = n_x - CMP_W'(1);
         end
         ACT_REM_AT: begin
            dec_rem = 1'b1;
            at_x    = pos_x;
         end
         default: begin
         end
      endcase
      if (dec_ins) begin
         if (n_x >= CMP_W'(CAPACITY)) begin
            dec_status = ST_FULL;
         end else if (at_x > n_x) begin
            dec_status = ST_RANGE;
         end
      end else if (dec_rem) begin
         if (n_x == '0) begin
            dec_status = ST_EMPTY;
         end else if (at_x >= n_x) begin
            dec_status = ST_RANGE;
         end
      end
   end

   assign ok_ins = is_ins_ff && (status_ff == ST_OK);
   assign ok_rem = is_rem_ff && (status_ff == ST_OK);

   // move sequencer: one read per cycle, each move write lands in the cycle after its read
   always_comb begin
      is_ins_in   = is_ins_ff;
      is_rem_in   = is_rem_ff;
      status_in   = status_ff;
      at_in       = at_ff;
      handle_in   = handle_ff;
      left_in     = left_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_addr_in  = wr_addr_ff;
      wr_pend_in  = 1'b0;
      cap_pend_in = 1'b0;
      first_in    = first_ff;
      taken_in    = taken_ff;
      mem_raddr   = rd_ptr_ff;

      if (cmd.start) begin
         is_ins_in = dec_ins;
         is_rem_in = dec_rem;
         status_in = dec_status;
         at_in     = ADDR_W'(at_x);
         handle_in = req_item_handle;
         first_in  = 1'b1;
         taken_in  = '0;
         if ((dec_ins || dec_rem) && (dec_status == ST_OK)) begin
            left_in = CNT_W'(n_x - at_x);
         end else begin
            left_in = '0;
         end
         // insert walks down from the top entry, remove walks up from the gap
         if (dec_ins) begin
            rd_ptr_in = ADDR_W'(n_x - CMP_W'(1));
         end else begin
            rd_ptr_in = ADDR_W'(at_x);
         end
      end else if (cmd.step) begin
         if (cap_pend_ff) begin
            taken_in = mem_rdata;
         end
         if (left_ff != '0) begin
            left_in  = left_ff - CNT_W'(1);
            first_in = 1'b0;
            if (is_ins_ff) begin
               rd_ptr_in   = rd_ptr_ff - ADDR_W'(1);
               wr_addr_in  = rd_ptr_ff + ADDR_W'(1);
               wr_pend_in  = 1'b1;
            end else begin
               rd_ptr_in   = rd_ptr_ff + ADDR_W'(1);
               wr_addr_in  = rd_ptr_ff - ADDR_W'(1);
               wr_pend_in  = !first_ff;
               cap_pend_in = first_ff;
            end
         end
      end
   end

   // trailing move write, or the new handle on an insert commit
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = mem_rdata;
      if (wr_pend_ff) begin
         mem_we = 1'b1;
      end else if (cmd.commit && ok_ins) begin
         mem_we    = 1'b1;
         mem_waddr = at_ff;
         mem_wdata = handle_ff;
      end
   end

   // count update and result register load
   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         if (ok_ins) begin
            count_in = count_ff + CNT_W'(1);
         end else if (ok_rem) begin
            count_in = count_ff - CNT_W'(1);
         end
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_removed_in = ok_rem ? taken_ff : '0;
         rsp_count_in   = count_in;
      end
   end

   assign sts.done     = (left_ff == '0) && !wr_pend_ff && !cap_pend_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         left_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         cap_pend_ff  <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         wr_pend_ff   <= wr_pend_in;
         cap_pend_ff  <= cap_pend_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      is_ins_ff      <= is_ins_in;
      is_rem_ff      <= is_rem_in;
      status_ff      <= status_in;
      at_ff          <= at_in;
      handle_ff      <= handle_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_addr_ff     <= wr_addr_in;
      taken_ff       <= taken_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_handle = rsp_removed_ff;
   assign rsp_entry_count    = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");
   a_count_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count_ff))
      else $error("entry count changed outside commit");
   a_no_move_at_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !wr_pend_ff && !cap_pend_ff && (left_ff == '0))
      else $error("commit while moves still in flight");
`endif

endmodule

// File: sv/positional_list_engine.sv
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl, ple_dpath (which holds ple_ram).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/ready, action, position, item | in
//   rsp     | rsp_valid/ready, status, removed, count | out
//
// An action reads no slot when it is an error, a no-op or an insert back, else
// it reads count - index slots (up to 256) before its commit.
// The single read port and write port of the slot RAM move one entry a cycle.
// The result word loads into the output register at the edge ending the commit.
// While a result is held one more word is accepted; its commit then waits.
// Reset clears the count to zero; slot contents are undefined until written.
module positional_list_engine
   import ple_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [POS_W-1:0]       req_position,
   input  logic [HANDLE_BITS-1:0] req_item_handle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_removed_handle,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_item_handle    (req_item_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_removed_handle (rsp_removed_handle),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

// File: tb/positional_list_engine_tb.sv
// Self-checking testbench for positional_list_engine: random valid/ready traffic on both sides,
// with a cycle-free list predictor checked result word by result word.
// Depends on ple_pkg and the positional_list_engine RTL only.
module positional_list_engine_tb
   import ple_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // action codes the block treats as no operation
   localparam logic [ACTION_W-1:0] ACT_NOP_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_NOP_7 = 3'd7;

   localparam int MAX_POS      = (1 << POS_W) - 1;
   localparam int MAX_HANDLE   = (1 << HANDLE_BITS) - 1;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic [ACTION_W-1:0]    action;
      logic [POS_W-1:0]       position;
      logic [HANDLE_BITS-1:0] handle;
   } list_word_type;

   typedef struct {
      status_type             status;
      logic [HANDLE_BITS-1:0] removed;
      logic [CNT_W-1:0]       count;
   } list_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ACTION_W-1:0]    req_action = '0;
   logic [POS_W-1:0]       req_position = '0;
   logic [HANDLE_BITS-1:0] req_item_handle = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [HANDLE_BITS-1:0] rsp_removed_handle;
   logic [CNT_W-1:0]       rsp_entry_count;

   list_word_type   pending_words[$];
   list_result_type expected_results[$];

   // predictor copy of the list
   logic [HANDLE_BITS-1:0] slot_copy [CAPACITY];
   int unsigned            copy_length = 0;

   // list length as the stimulus builder sees it, for picking positions
   int unsigned gen_count = 0;

   int send_idle_pct = 9;
   int rsp_idle_pct  = 67;
   logic hold_req = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int result_index = 0;

   positional_list_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_item_handle    (req_item_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_removed_handle (rsp_removed_handle),
      .rsp_entry_count    (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR result %0d: %s", result_index, msg);
      error_count++;
   endtask

   // Apply one action to the list copy and return the result word it yields.
   function automatic list_result_type apply_list_action(input list_word_type w);
      list_result_type r;
      int unsigned     at;
      bit              is_insert;
      r.status  = ST_OK;
      r.removed = '0;
      is_insert = 1'b1;
      at        = 0;
      case (w.action)
         ACT_INS_FRONT: at = 0;
         ACT_INS_BACK:  at = copy_length;
         ACT_INS_AT:    at = 32'(w.position);
         ACT_REM_FRONT: begin
            is_insert = 1'b0;
            at = 0;
         end
         ACT_REM_BACK: begin
            is_insert = 1'b0;
            at = (copy_length == 0) ? 0 : copy_length - 1;
         end
         ACT_REM_AT: begin
            is_insert = 1'b0;
            at = 32'(w.position);
         end
         default: begin
            r.count = copy_length[CNT_W-1:0];
            return r;
         end
      endcase
      if (is_insert) begin
         if (copy_length >= CAPACITY) begin
            r.status = ST_FULL;
         end else if (at > copy_length) begin
            r.status = ST_RANGE;
         end else begin
            for (int k = copy_length; k > at; k--) slot_copy[k] = slot_copy[k-1];
            slot_copy[at] = w.handle;
            copy_length++;
         end
      end else begin
         if (copy_length == 0) begin
            r.status = ST_EMPTY;
         end else if (at >= copy_length) begin
            r.status = ST_RANGE;
         end else begin
            r.removed = slot_copy[at];
            copy_length--;
            for (int k = at; k < copy_length; k++) slot_copy[k] = slot_copy[k+1];
         end
      end
      r.count = copy_length[CNT_W-1:0];
      return r;
   endfunction

   // Queue one word for the driver and track the length it leaves behind.
   task automatic push_item(input logic [ACTION_W-1:0] action, input int unsigned position,
                            input int unsigned handle);
      list_word_type w;
      w.action   = action;
      w.position = position[POS_W-1:0];
      w.handle   = handle[HANDLE_BITS-1:0];
      pending_words.push_back(w);
      case (action)
         ACT_INS_FRONT, ACT_INS_BACK: if (gen_count < CAPACITY) gen_count++;
         ACT_INS_AT: if (gen_count < CAPACITY && 32'(w.position) <= gen_count) gen_count++;
         ACT_REM_FRONT, ACT_REM_BACK: if (gen_count > 0) gen_count--;
         ACT_REM_AT: if (gen_count > 0 && 32'(w.position) < gen_count) gen_count--;
         default: ;
      endcase
   endtask

   // Random walk that keeps the list short, so shifts stay cheap.
   task automatic gen_walk(input int n);
      int unsigned r;
      int unsigned ins_pct;
      int unsigned pos;
      logic [ACTION_W-1:0] act;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         ins_pct = (gen_count > 20) ? 35 : 55;
         pos = $urandom_range(MAX_POS);
         if (r < 4) begin
            act = ($urandom_range(1) == 1) ? ACT_NOP_7 : ACT_NOP_6;
         end else if (r < 4 + ins_pct) begin
            case ($urandom_range(2))
               0: act = ACT_INS_FRONT;
               1: act = ACT_INS_BACK;
               default: begin
                  act = ACT_INS_AT;
                  if ($urandom_range(99) < 85) pos = $urandom_range(gen_count);
               end
            endcase
         end else begin
            case ($urandom_range(2))
               0: act = ACT_REM_FRONT;
               1: act = ACT_REM_BACK;
               default: begin
                  act = ACT_REM_AT;
                  if ($urandom_range(99) < 85)
                     pos = (gen_count == 0) ? 0 : $urandom_range(gen_count - 1);
               end
            endcase
         end
         push_item(act, pos, $urandom_range(MAX_HANDLE));
      end
   endtask

   // Block until the driver has nothing left and every result word is back.
   task automatic wait_quiet();
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Driver: predict at acceptance, then offer the next word or idle.
   always @(posedge clock) begin
      list_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            w.action   = req_action;
            w.position = req_position;
            w.handle   = req_item_handle;
            expected_results.push_back(apply_list_action(w));
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               w = pending_words.pop_front();
               req_action      <= w.action;
               req_position    <= w.position;
               req_item_handle <= w.handle;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted down here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_req) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      list_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               e = expected_results.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, e.status));
               if (rsp_removed_handle !== e.removed)
                  report_mismatch($sformatf("removed_handle got %0d expected %0d",
                                            rsp_removed_handle, e.removed));
               if (rsp_entry_count !== e.count)
                  report_mismatch($sformatf("entry_count got %0d expected %0d",
                                            rsp_entry_count, e.count));
            end
            result_index++;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Stimulus phases
   initial begin
      int unsigned r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, range errors, every action, field extremes
      push_item(ACT_REM_FRONT, 0, 0);
      push_item(ACT_REM_BACK, MAX_POS, MAX_HANDLE);
      push_item(ACT_REM_AT, 0, 0);
      push_item(ACT_REM_AT, MAX_POS, 0);
      push_item(ACT_INS_AT, 1, 7);
      push_item(ACT_INS_AT, MAX_POS, MAX_HANDLE);
      push_item(ACT_INS_FRONT, 0, 0);
      push_item(ACT_INS_BACK, MAX_POS, MAX_HANDLE);
      push_item(ACT_INS_AT, 2, 'h155);
      push_item(ACT_INS_AT, 1, 'h2aa);
      push_item(ACT_INS_AT, 0, 'h3c3);
      push_item(ACT_INS_AT, 256, 'h0f0);
      push_item(ACT_NOP_6, MAX_POS, MAX_HANDLE);
      push_item(ACT_NOP_7, 0, 0);
      push_item(ACT_REM_AT, 5, 0);
      push_item(ACT_REM_AT, MAX_POS, 0);
      push_item(ACT_REM_AT, 2, MAX_HANDLE);
      push_item(ACT_REM_AT, 3, 0);
      push_item(ACT_REM_FRONT, 0, 0);
      push_item(ACT_REM_BACK, 0, 0);
      push_item(ACT_REM_AT, 0, 0);
      push_item(ACT_INS_BACK, 0, 'h200);
      push_item(ACT_REM_BACK, 0, 0);
      gen_walk(600);
      wait_quiet();

      // swap idling; open with a long receiver hold so the block backs up
      send_idle_pct = 67;
      rsp_idle_pct  = 9;
      hold_req = 1'b1;
      gen_walk(600);
      @(negedge clock);
      hold_req = 1'b0;
      wait_quiet();

      // full speed: fill to capacity, hit the full cases, then drain
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      while (gen_count < CAPACITY) begin
         r = $urandom_range(99);
         if (r < 88) push_item(ACT_INS_BACK, $urandom_range(MAX_POS), $urandom_range(MAX_HANDLE));
         else if (r < 96) push_item(ACT_INS_AT, $urandom_range(gen_count),
                                    $urandom_range(MAX_HANDLE));
         else push_item(ACT_INS_FRONT, 0, $urandom_range(MAX_HANDLE));
      end
      push_item(ACT_INS_FRONT, 0, MAX_HANDLE);
      push_item(ACT_INS_BACK, 0, 1);
      push_item(ACT_INS_AT, 0, 2);
      push_item(ACT_INS_AT, CAPACITY, 3);
      push_item(ACT_INS_AT, MAX_POS, 4);
      push_item(ACT_REM_AT, CAPACITY, 0);
      push_item(ACT_REM_AT, MAX_POS, 0);
      push_item(ACT_REM_AT, CAPACITY - 1, 0);
      push_item(ACT_INS_AT, CAPACITY, 5);
      push_item(ACT_INS_AT, CAPACITY - 1, MAX_HANDLE);
      push_item(ACT_INS_BACK, 0, 6);
      while (gen_count > 0) begin
         r = $urandom_range(99);
         if (r < 85) push_item(ACT_REM_BACK, 0, 0);
         else if (r < 92) push_item(ACT_REM_FRONT, $urandom_range(MAX_POS), 0);
         else push_item(ACT_REM_AT, $urandom_range(gen_count - 1), $urandom_range(MAX_HANDLE));
      end
      gen_walk(100);
      wait_quiet();

      // let any stray result word surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("positional_list_engine verification clean");
      end else begin
         $display("positional_list_engine verification failed");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #80_000_000;
      $display("positional_list_engine verification failed");
      $finish;
   end

endmodule
